@@ rtl/core/sbt_pkg.sv @@
// Shared types, constants and microprogram for the square bitmap transform.
// No dependencies; used by every file of the block.
package sbt_pkg;

  localparam int SIDE     = 16;
  localparam int IDX_W    = $clog2(SIDE);
  localparam int FIELD_W  = 16;
  localparam int LANE_W   = 8;
  localparam int BYTE_MSB = 7;

  typedef logic [SIDE-1:0] row_t;

  typedef enum logic [3:0] {
    OP_WRITE     = 4'd0,
    OP_READ      = 4'd1,
    OP_ROTATE    = 4'd2,
    OP_SHIFT     = 4'd3,
    OP_INVERT    = 4'd4,
    OP_BREV      = 4'd5,
    OP_MIRROR    = 4'd6,
    OP_FLIP      = 4'd7,
    OP_TRANSPOSE = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_WRITE,
    DP_READ,
    DP_TRANSPOSE,
    DP_FLIP,
    DP_MIRROR,
    DP_INVERT,
    DP_BREV,
    DP_SHIFT
  } dp_op_t;

  typedef logic [3:0] upc_t;

  // one microcode word
  typedef struct packed {
    dp_op_t op;
    logic   last;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    logic   fire;
    dp_op_t op;
  } dp_ctrl_t;

  localparam upc_t UPC_WRITE     = 4'd0;
  localparam upc_t UPC_READ      = 4'd1;
  localparam upc_t UPC_ROT_90    = 4'd2;
  localparam upc_t UPC_ROT_180   = 4'd4;
  localparam upc_t UPC_ROT_270   = 4'd6;
  localparam upc_t UPC_SHIFT     = 4'd8;
  localparam upc_t UPC_INVERT    = 4'd9;
  localparam upc_t UPC_BREV      = 4'd10;
  localparam upc_t UPC_MIRROR    = 4'd11;
  localparam upc_t UPC_FLIP      = 4'd12;
  localparam upc_t UPC_TRANSPOSE = 4'd13;
  localparam upc_t UPC_NOP       = 4'd14;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '{op: DP_NOP, last: 1'b1};
    case (pc)
      UPC_WRITE:                 w = '{op: DP_WRITE,     last: 1'b1};
      UPC_READ:                  w = '{op: DP_READ,      last: 1'b1};
      UPC_ROT_90:                w = '{op: DP_TRANSPOSE, last: 1'b0};
      upc_t'(UPC_ROT_90 + 1):    w = '{op: DP_FLIP,      last: 1'b1};
      UPC_ROT_180:               w = '{op: DP_FLIP,      last: 1'b0};
      upc_t'(UPC_ROT_180 + 1):   w = '{op: DP_MIRROR,    last: 1'b1};
      UPC_ROT_270:               w = '{op: DP_TRANSPOSE, last: 1'b0};
      upc_t'(UPC_ROT_270 + 1):   w = '{op: DP_MIRROR,    last: 1'b1};
      UPC_SHIFT:                 w = '{op: DP_SHIFT,     last: 1'b1};
      UPC_INVERT:                w = '{op: DP_INVERT,    last: 1'b1};
      UPC_BREV:                  w = '{op: DP_BREV,      last: 1'b1};
      UPC_MIRROR:                w = '{op: DP_MIRROR,    last: 1'b1};
      UPC_FLIP:                  w = '{op: DP_FLIP,      last: 1'b1};
      UPC_TRANSPOSE:             w = '{op: DP_TRANSPOSE, last: 1'b1};
      default:                   w = '{op: DP_NOP,       last: 1'b1};
    endcase
    return w;
  endfunction

  // dispatch: operation and rotation pick the program entry
  function automatic upc_t entry(logic [3:0] op, logic [1:0] rot);
    upc_t pc;
    pc = UPC_NOP;
    case (op)
      OP_WRITE:     pc = UPC_WRITE;
      OP_READ:      pc = UPC_READ;
      OP_ROTATE: begin
        case (rot)
          ROT_90:  pc = UPC_ROT_90;
          ROT_180: pc = UPC_ROT_180;
          ROT_270: pc = UPC_ROT_270;
          default: pc = UPC_NOP;
        endcase
      end
      OP_SHIFT:     pc = UPC_SHIFT;
      OP_INVERT:    pc = UPC_INVERT;
      OP_BREV:      pc = UPC_BREV;
      OP_MIRROR:    pc = UPC_MIRROR;
      OP_FLIP:      pc = UPC_FLIP;
      OP_TRANSPOSE: pc = UPC_TRANSPOSE;
      default:      pc = UPC_NOP;
    endcase
    return pc;
  endfunction

endpackage

@@ rtl/core/sbt_useq.sv @@
// Microcode sequencer: step counter over the control ROM in sbt_pkg.
// Depends on sbt_pkg.
module sbt_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [3:0]          operation,
  input  logic [1:0]          rotation,
  input  logic                out_full,
  output logic                ready,
  output sbt_pkg::dp_ctrl_t   ctrl
);

  sbt_pkg::upc_t   pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  sbt_pkg::uword_t uw;
  logic            fire;

  assign uw    = sbt_pkg::ucode(pc_r);
  // a read step waits for the output register
  assign fire  = busy_r && !(out_full && (uw.op == sbt_pkg::DP_READ));
  assign ready = !busy_r || (fire && uw.last);

  assign ctrl.fire = fire;
  assign ctrl.op   = uw.op;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = sbt_pkg::entry(operation, rotation);
      busy_nxt = 1'b1;
    end else if (fire) begin
      if (uw.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= sbt_pkg::UPC_NOP;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

@@ rtl/core/sbt_dp.sv @@
// Datapath: pixel row registers with whole-array transforms and row access.
// Depends on sbt_pkg; driven by sbt_useq.
module sbt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [3:0]          row_index,
  input  logic [15:0]         row_data,
  input  logic                recycle,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_dir,
  input  sbt_pkg::dp_ctrl_t   ctrl,
  output logic [15:0]         read_row
);

  localparam int SIDE = sbt_pkg::SIDE;

  sbt_pkg::row_t rows_r   [SIDE];
  sbt_pkg::row_t rows_nxt [SIDE];
  sbt_pkg::row_t trn [SIDE];
  sbt_pkg::row_t flp [SIDE];
  sbt_pkg::row_t mir [SIDE];
  sbt_pkg::row_t inv [SIDE];
  sbt_pkg::row_t brv [SIDE];
  sbt_pkg::row_t shf [SIDE];

  logic [3:0]                 idx_r;
  logic [15:0]                data_r;
  logic                       recycle_r;
  sbt_pkg::dir_t              dir_r;
  logic                       in_range;
  logic [sbt_pkg::IDX_W-1:0]  sel;
  sbt_pkg::row_t              wdata;
  logic [SIDE+sbt_pkg::FIELD_W-1:0] wext, rext;

  assign in_range = 32'(idx_r) < SIDE;
  assign sel      = sbt_pkg::IDX_W'(idx_r);
  assign wext     = (SIDE + sbt_pkg::FIELD_W)'(data_r);
  assign wdata    = wext[SIDE-1:0];
  assign rext     = (SIDE + sbt_pkg::FIELD_W)'(rows_r[sel]);
  assign read_row = in_range ? rext[sbt_pkg::FIELD_W-1:0] : '0;

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        trn[c][SIDE-1-r] = rows_r[r][SIDE-1-c];
        mir[r][SIDE-1-c] = rows_r[r][c];
      end
      flp[r] = rows_r[SIDE-1-r];
      inv[r] = ~rows_r[r];
    end
  end

  // bit order reversed inside 8-bit lanes aligned at bit 0
  always_comb begin
    logic [SIDE+sbt_pkg::LANE_W-1:0] bext;
    int src;
    bext = '0;
    src  = 0;
    for (int r = 0; r < SIDE; r++) begin
      bext = (SIDE + sbt_pkg::LANE_W)'(rows_r[r]);
      for (int b = 0; b < SIDE; b++) begin
        src = (b / sbt_pkg::LANE_W) * sbt_pkg::LANE_W + sbt_pkg::BYTE_MSB
              - (b % sbt_pkg::LANE_W);
        brv[r][b] = (src < SIDE) ? bext[src] : 1'b0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      shf[r] = rows_r[r];
    end
    case (dir_r)
      sbt_pkg::DIR_LEFT: begin
        for (int r = 0; r < SIDE; r++) begin
          shf[r] = {rows_r[r][SIDE-2:0], recycle_r & rows_r[r][SIDE-1]};
        end
      end
      sbt_pkg::DIR_RIGHT: begin
        for (int r = 0; r < SIDE; r++) begin
          shf[r] = {recycle_r & rows_r[r][0], rows_r[r][SIDE-1:1]};
        end
      end
      sbt_pkg::DIR_UP: begin
        for (int r = 0; r < SIDE - 1; r++) begin
          shf[r] = rows_r[r+1];
        end
        shf[SIDE-1] = recycle_r ? rows_r[0] : '0;
      end
      sbt_pkg::DIR_DOWN: begin
        for (int r = 1; r < SIDE; r++) begin
          shf[r] = rows_r[r-1];
        end
        shf[0] = recycle_r ? rows_r[SIDE-1] : '0;
      end
      default: begin
        for (int r = 0; r < SIDE; r++) begin
          shf[r] = rows_r[r];
        end
      end
    endcase
  end

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      rows_nxt[r] = rows_r[r];
    end
    if (ctrl.fire) begin
      case (ctrl.op)
        sbt_pkg::DP_WRITE: begin
          if (in_range) begin
            rows_nxt[sel] = wdata;
          end
        end
        sbt_pkg::DP_TRANSPOSE: rows_nxt = trn;
        sbt_pkg::DP_FLIP:      rows_nxt = flp;
        sbt_pkg::DP_MIRROR:    rows_nxt = mir;
        sbt_pkg::DP_INVERT:    rows_nxt = inv;
        sbt_pkg::DP_BREV:      rows_nxt = brv;
        sbt_pkg::DP_SHIFT:     rows_nxt = shf;
        default: begin
          for (int r = 0; r < SIDE; r++) begin
            rows_nxt[r] = rows_r[r];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SIDE; r++) begin
        rows_r[r] <= '0;
      end
      dir_r <= sbt_pkg::DIR_DOWN;
    end else begin
      rows_r <= rows_nxt;
      if (cfg_we) begin
        dir_r <= sbt_pkg::dir_t'(cfg_dir);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx_r     <= row_index;
      data_r    <= row_data;
      recycle_r <= recycle;
    end
  end

endmodule

@@ rtl/core/square_bitmap_transform_top.sv @@
// Top level of the square bitmap transform: stream ports, output register.
// Depends on sbt_pkg, sbt_useq and sbt_dp.
//
// A 16x16 one-bit bitmap held in flip-flops, cleared by reset. Each word on
// the input stream is one operation, run by a microprogram of one or two
// steps, one step per clock while no read step waits: rotation by 90, 180 or
// 270 degrees takes two steps (two whole-array passes), every other operation
// one step. The next word is taken in the cycle the last step runs. Only a
// row read produces an output word; it lands in an output register, and a
// further read step waits while that register is still unread. The shift
// direction register is written through the cfg port, which is always ready;
// write it only while the block is idle.
module square_bitmap_transform_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row_index[3:0], row_data[19:4], rotation[21:20],
                                  // recycle[22], zero[23]
  input  logic [3:0]  in_tuser,   // operation[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_row[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // move_direction[1:0]
);

  sbt_pkg::dp_ctrl_t ctrl;
  logic              start;
  logic              ready;
  logic              out_full;
  logic [15:0]       read_row;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_data_r;

  assign in_tready  = ready;
  assign start      = in_tvalid && ready;
  assign cfg_ready  = 1'b1;
  assign out_full   = out_valid_r && !out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  sbt_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_tuser),
    .rotation  (in_tdata[21:20]),
    .out_full  (out_full),
    .ready     (ready),
    .ctrl      (ctrl)
  );

  sbt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (start),
    .row_index (in_tdata[3:0]),
    .row_data  (in_tdata[19:4]),
    .recycle   (in_tdata[22]),
    .cfg_we    (cfg_valid),
    .cfg_dir   (cfg_data),
    .ctrl      (ctrl),
    .read_row  (read_row)
  );

  logic rd_fire;
  assign rd_fire = ctrl.fire && (ctrl.op == sbt_pkg::DP_READ);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      out_data_r <= read_row;
    end
  end

endmodule

@@ rtl/core/sbt_check.sv @@
// Port-level checker for square_bitmap_transform_top, bound to the top level.
// Depends on sbt_pkg and square_bitmap_transform_top.
module sbt_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [3:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic wr_acc, rd_acc;
  assign wr_acc = in_tvalid && in_tready && (in_tuser == sbt_pkg::OP_WRITE);
  assign rd_acc = in_tvalid && in_tready && (in_tuser == sbt_pkg::OP_READ);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");

  // nothing pending right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // read directly after a write of the same row returns the written pixels
  a_rd_after_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc ##1 (rd_acc && !out_tvalid && (in_tdata[3:0] == $past(in_tdata[3:0])))
    |=> ##1 (out_tvalid && (out_tdata == $past(in_tdata[19:4], 3))))
    else $error("read after write mismatch");

endmodule

bind square_bitmap_transform_top sbt_check u_sbt_check (.*);

@@ bench/tb_square_bitmap_transform_top.sv @@
// Self-checking bench for square_bitmap_transform_top: directed and random
// stream traffic with bursts and stalls, checked against a bitmap predictor
// in a scoreboard. Depends on sbt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_square_bitmap_transform_top;

  localparam int          CLK_PERIOD  = 8;
  localparam int          RESET_CYC   = 11;
  localparam int          HOLD_CYC    = 200;
  localparam int          PHASE_WORDS = 150;
  localparam int          DRAIN_CYC   = 8;
  localparam int          SIDE        = sbt_pkg::SIDE;
  localparam int          LANE_W      = sbt_pkg::LANE_W;
  localparam logic [3:0]  OP_CODE_MAX = 4'hF;

  typedef logic [sbt_pkg::FIELD_W-1:0] field_t;
  typedef logic [sbt_pkg::IDX_W-1:0]   idx_t;

  typedef struct packed {
    logic [3:0]    op;
    idx_t          idx;
    field_t        data;
    sbt_pkg::rot_t rot;
    logic          rec;
  } word_t;

  // bitmap predictor plus queue of pending read_row values
  class bitmap_scoreboard;
    sbt_pkg::row_t rows[SIDE];
    sbt_pkg::dir_t dir;
    field_t        read_rows[$];
    int            errors;

    function new();
      foreach (rows[r]) rows[r] = '0;
      dir    = sbt_pkg::DIR_DOWN;
      errors = 0;
    endfunction

    function void set_direction(sbt_pkg::dir_t d);
      dir = d;
    endfunction

    function int pending();
      return read_rows.size();
    endfunction

    function void transpose();
      sbt_pkg::row_t tmp[SIDE];
      foreach (tmp[c]) tmp[c] = '0;
      for (int r = 0; r < SIDE; r++)
        for (int c = 0; c < SIDE; c++)
          tmp[c][SIDE-1-r] = rows[r][SIDE-1-c];
      rows = tmp;
    endfunction

    function void flip();
      sbt_pkg::row_t t;
      for (int r = 0; r < SIDE / 2; r++) begin
        t              = rows[r];
        rows[r]        = rows[SIDE-1-r];
        rows[SIDE-1-r] = t;
      end
    endfunction

    function void mirror();
      sbt_pkg::row_t o;
      for (int r = 0; r < SIDE; r++) begin
        for (int b = 0; b < SIDE; b++) o[SIDE-1-b] = rows[r][b];
        rows[r] = o;
      end
    endfunction

    function void byte_reverse();
      sbt_pkg::row_t o;
      int            src;
      for (int r = 0; r < SIDE; r++) begin
        for (int i = 0; i < SIDE; i++) begin
          src  = (i / LANE_W) * LANE_W + (LANE_W - 1 - i % LANE_W);
          o[i] = (src < SIDE) ? rows[r][src] : 1'b0;
        end
        rows[r] = o;
      end
    endfunction

    function void shift(logic rec);
      sbt_pkg::row_t keep;
      case (dir)
        sbt_pkg::DIR_LEFT: begin
          for (int r = 0; r < SIDE; r++)
            rows[r] = {rows[r][SIDE-2:0], rec & rows[r][SIDE-1]};
        end
        sbt_pkg::DIR_RIGHT: begin
          for (int r = 0; r < SIDE; r++)
            rows[r] = {rec & rows[r][0], rows[r][SIDE-1:1]};
        end
        sbt_pkg::DIR_UP: begin
          keep = rows[0];
          for (int r = 0; r < SIDE - 1; r++) rows[r] = rows[r+1];
          rows[SIDE-1] = rec ? keep : '0;
        end
        default: begin
          keep = rows[SIDE-1];
          for (int r = SIDE - 1; r > 0; r--) rows[r] = rows[r-1];
          rows[0] = rec ? keep : '0;
        end
      endcase
    endfunction

    function void note_word(word_t w);
      case (w.op)
        sbt_pkg::OP_WRITE: begin
          if (w.idx < SIDE) rows[w.idx] = sbt_pkg::row_t'(w.data);
        end
        sbt_pkg::OP_READ: begin
          read_rows.push_back((w.idx < SIDE) ? field_t'(rows[w.idx]) : '0);
        end
        sbt_pkg::OP_ROTATE: begin
          case (w.rot)
            sbt_pkg::ROT_90:  begin transpose(); flip();   end
            sbt_pkg::ROT_180: begin flip();      mirror(); end
            sbt_pkg::ROT_270: begin transpose(); mirror(); end
            default: ;
          endcase
        end
        sbt_pkg::OP_SHIFT:     shift(w.rec);
        sbt_pkg::OP_INVERT:    foreach (rows[r]) rows[r] = ~rows[r];
        sbt_pkg::OP_BREV:      byte_reverse();
        sbt_pkg::OP_MIRROR:    mirror();
        sbt_pkg::OP_FLIP:      flip();
        sbt_pkg::OP_TRANSPOSE: transpose();
        default:               ;
      endcase
    endfunction

    function void check_row(field_t got);
      field_t want;
      if (read_rows.size() == 0) begin
        $display("%0t: unexpected word, read_row actual %h, expected none", $time, got);
        errors++;
      end else begin
        want = read_rows.pop_front();
        if (got !== want) begin
          $display("%0t: read_row mismatch, expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [23:0]       in_tdata;
  logic [3:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_data;

  bitmap_scoreboard  sb = new();
  int                burst_left = 0;
  bit                hold_req   = 1'b0;
  bit                hold_active = 1'b0;

  square_bitmap_transform_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_row(out_tdata);
  end

  // receiver: stall pattern, plus long hold-off on request
  initial begin
    int mode;
    int len;
    int cnt;
    out_tready = 1'b0;
    cnt        = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 40);
      for (int i = 0; i < len && !hold_req; i++) begin
        @(negedge clk);
        cnt++;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= cnt[1];
        endcase
      end
    end
  end

  function automatic word_t mk_word(logic [3:0] op, idx_t idx, field_t data,
                                    sbt_pkg::rot_t rot, logic rec);
    word_t w;
    w.op   = op;
    w.idx  = idx;
    w.data = data;
    w.rot  = rot;
    w.rec  = rec;
    return w;
  endfunction

  task automatic stop_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_word(word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, w.rec, w.rot, w.data, w.idx};
    in_tuser  <= w.op;
    do @(posedge clk); while (!in_tready);
    sb.note_word(w);
  endtask

  task automatic send_random();
    int         pick;
    logic [3:0] op;
    field_t     data;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = sbt_pkg::OP_WRITE;
    else if (pick < 55) op = sbt_pkg::OP_READ;
    else if (pick < 60) op = 4'($urandom_range(sbt_pkg::OP_TRANSPOSE + 1, OP_CODE_MAX));
    else                op = 4'($urandom_range(sbt_pkg::OP_ROTATE, sbt_pkg::OP_TRANSPOSE));
    case ($urandom_range(0, 5))
      0:       data = '0;
      1:       data = '1;
      2:       data = field_t'(1) << $urandom_range(0, sbt_pkg::FIELD_W - 1);
      default: data = field_t'($urandom);
    endcase
    send_word(mk_word(op, idx_t'($urandom), data, sbt_pkg::rot_t'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1))));
  endtask

  // wait for every pending read, then let a two-step rotation finish
  task automatic settle();
    stop_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_direction(sbt_pkg::dir_t d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_direction(d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // long receiver hold-off while reads keep coming, so the input stalls
  task automatic press_output();
    stop_input();
    hold_req = 1'b1;
    wait (hold_active);
    burst_left = 30;
    for (int i = 0; i < 12; i++)
      send_word(mk_word(sbt_pkg::OP_READ, idx_t'($urandom), field_t'($urandom),
                        sbt_pkg::rot_t'($urandom_range(0, 3)), 1'b0));
  endtask

  initial begin
    sbt_pkg::dir_t phase_dirs[6];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset state, field extremes, every operation, unused codes
    send_word(mk_word(sbt_pkg::OP_READ,  4'd0,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_WRITE, 4'd0,  16'hFFFF, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_WRITE, 4'd15, 16'h8001, sbt_pkg::ROT_270,  1'b1));
    send_word(mk_word(sbt_pkg::OP_WRITE, 4'd7,  16'hA5C3, sbt_pkg::ROT_90,   1'b0));
    send_word(mk_word(sbt_pkg::OP_WRITE, 4'd8,  16'h0001, sbt_pkg::ROT_180,  1'b1));
    send_word(mk_word(sbt_pkg::OP_READ,  4'd15, 16'hFFFF, sbt_pkg::ROT_270,  1'b1));
    send_word(mk_word(sbt_pkg::OP_ROTATE, 4'd0, 16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_READ,  4'd7,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_ROTATE, 4'd0, 16'h0000, sbt_pkg::ROT_90,   1'b0));
    send_word(mk_word(sbt_pkg::OP_READ,  4'd0,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_ROTATE, 4'd0, 16'h0000, sbt_pkg::ROT_180,  1'b0));
    send_word(mk_word(sbt_pkg::OP_READ,  4'd15, 16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_ROTATE, 4'd0, 16'h0000, sbt_pkg::ROT_270,  1'b0));
    send_word(mk_word(sbt_pkg::OP_READ,  4'd8,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_SHIFT, 4'd0,  16'h0000, sbt_pkg::ROT_NONE, 1'b1));
    send_word(mk_word(sbt_pkg::OP_SHIFT, 4'd0,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_READ,  4'd0,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_INVERT, 4'd0, 16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_BREV,  4'd0,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_MIRROR, 4'd0, 16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_FLIP,  4'd0,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(sbt_pkg::OP_TRANSPOSE, 4'd0, 16'h0000, sbt_pkg::ROT_NONE, 1'b0));
    send_word(mk_word(4'(sbt_pkg::OP_TRANSPOSE + 1), 4'd3, 16'h1234, sbt_pkg::ROT_90, 1'b1));
    send_word(mk_word(OP_CODE_MAX, 4'd9, 16'hFFFF, sbt_pkg::ROT_270, 1'b1));
    send_word(mk_word(sbt_pkg::OP_READ,  4'd7,  16'h0000, sbt_pkg::ROT_NONE, 1'b0));

    phase_dirs = '{sbt_pkg::DIR_LEFT, sbt_pkg::DIR_RIGHT, sbt_pkg::DIR_UP, sbt_pkg::DIR_DOWN,
                   sbt_pkg::dir_t'($urandom_range(0, 3)),
                   sbt_pkg::dir_t'($urandom_range(0, 3))};
    foreach (phase_dirs[p]) begin
      settle();
      write_direction(phase_dirs[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ((p == 1 || p == 4) && i == PHASE_WORDS / 2) press_output();
        send_random();
      end
    end

    settle();
    if (sb.pending() != 0 || sb.errors != 0) begin
      $display("Testbench completed WITH ERRORS");
    end else begin
      $display("Testbench completed without errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sbt_pkg.sv
rtl/core/sbt_useq.sv
rtl/core/sbt_dp.sv
rtl/core/square_bitmap_transform_top.sv
rtl/core/sbt_check.sv
bench/tb_square_bitmap_transform_top.sv
